// ===== sv/nfsa_pkg.sv =====
// Package for the next-fit slot allocator.
// Holds the action and status codes, controller types and command/status structs.
// No dependencies.
package nfsa_pkg;

    // Action codes (input tuser bits 1:0)
    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Status codes (output tuser bits 1:0)
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    // Used bitmap is stored as rows of eight slots
    localparam int ROW_BITS = 8;
    localparam int ROW_SH   = 3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE_RD,
        S_FREE_WR,
        S_SCAN_RD,
        S_SCAN,
        S_RESP
    } t_state;

    // What an accepted transaction needs from the datapath
    typedef enum logic [1:0] {
        JOB_IMM,
        JOB_SCAN,
        JOB_FREE
    } t_job;

    typedef struct packed {
        logic load;
        logic free_rd;
        logic free_wr;
        logic scan_rd;
        logic scan_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_job job;
        logic hit;
        logic last_row;
        logic out_busy;
    } t_sts;

endpackage

// ===== sv/next_fit_slot_allocator.sv =====
// Top level of the next-fit slot allocator: controller plus datapath.
// Depends on nfsa_pkg, nfsa_ctrl, nfsa_datapath (and nfsa_ram below it).
//
// Keeps one used bit per slot of a SLOT_COUNT pool and a next-free pointer.
// Each input transaction gives exactly one result transaction. Allocate with
// no held slot scans next-fit from the pointer, wrapping, claims the first
// free slot (created = 1) and moves the pointer past it, or reports full;
// allocate with a held slot hands it back (created = 0). Free clears the
// held slot's bit; an index outside the pool returns the range status.
// Clear resets the pointer only. Used bits live in a RAM of eight-slot
// rows; per-row valid flops make every slot free right after reset, so no
// clearing pass is needed. One transaction is worked at a time, and the
// result sits in an output register so the next transaction is accepted
// while it waits. A free reads the held slot's row, then writes it back. A
// scanning allocate examines one row per cycle through the RAM read port,
// at most ceil(SLOT_COUNT/8) + 1 rows (17 for 128 slots). Input is taken
// again the cycle after the result is loaded, once the output register
// has room.
module next_fit_slot_allocator #(
    parameter int SLOT_COUNT = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] held_slot
    input  logic [2:0] s_axis_tuser,   // [1:0] action, [2] has_held_slot
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] granted_slot, [7] created
    output logic [1:0] m_axis_tuser    // [1:0] status
);
    nfsa_pkg::t_cmd cmd;
    nfsa_pkg::t_sts sts;

    nfsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    nfsa_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tuser   (s_axis_tuser),
        .i_out_tready (m_axis_tready),
        .o_out_tvalid (m_axis_tvalid),
        .o_out_tdata  (m_axis_tdata),
        .o_out_tuser  (m_axis_tuser)
    );

endmodule

// ===== sv/nfsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/nfsa_ctrl.sv =====
// Controller state machine of the next-fit slot allocator.
// Depends on nfsa_pkg (state enum, command and status structs).
module nfsa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  nfsa_pkg::t_sts i_sts,
    output nfsa_pkg::t_cmd o_cmd
);
    nfsa_pkg::t_state r_state;
    nfsa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nfsa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            nfsa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    case (i_sts.job)
                        nfsa_pkg::JOB_SCAN: n_state = nfsa_pkg::S_SCAN_RD;
                        nfsa_pkg::JOB_FREE: n_state = nfsa_pkg::S_FREE_RD;
                        default:            n_state = nfsa_pkg::S_RESP;
                    endcase
                end
            end
            nfsa_pkg::S_FREE_RD: n_state = nfsa_pkg::S_FREE_WR;
            nfsa_pkg::S_FREE_WR: n_state = nfsa_pkg::S_RESP;
            nfsa_pkg::S_SCAN_RD: n_state = nfsa_pkg::S_SCAN;
            nfsa_pkg::S_SCAN: begin
                if (i_sts.hit || i_sts.last_row) begin
                    n_state = nfsa_pkg::S_RESP;
                end
            end
            nfsa_pkg::S_RESP: begin
                if (!i_sts.out_busy) begin
                    n_state = nfsa_pkg::S_IDLE;
                end
            end
            default: n_state = nfsa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            nfsa_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            nfsa_pkg::S_FREE_RD: o_cmd.free_rd   = 1'b1;
            nfsa_pkg::S_FREE_WR: o_cmd.free_wr   = 1'b1;
            nfsa_pkg::S_SCAN_RD: o_cmd.scan_rd   = 1'b1;
            nfsa_pkg::S_SCAN:    o_cmd.scan_step = 1'b1;
            nfsa_pkg::S_RESP:    o_cmd.out_load  = !i_sts.out_busy;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== sv/nfsa_datapath.sv =====
// Datapath of the next-fit slot allocator: used-bit rows, search pointer,
// row scan and result registers. Depends on nfsa_pkg and nfsa_ram.
module nfsa_datapath #(
    parameter int SLOT_COUNT = 128
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  nfsa_pkg::t_cmd i_cmd,
    output nfsa_pkg::t_sts o_sts,
    input  logic [7:0]     i_in_tdata,    // [7:0] held_slot
    input  logic [2:0]     i_in_tuser,    // [1:0] action, [2] has_held_slot
    input  logic           i_out_tready,
    output logic           o_out_tvalid,
    output logic [7:0]     o_out_tdata,   // [6:0] granted_slot, [7] created
    output logic [1:0]     o_out_tuser    // [1:0] status
);
    localparam int RB    = nfsa_pkg::ROW_BITS;
    localparam int SH    = nfsa_pkg::ROW_SH;
    localparam int ROWS  = (SLOT_COUNT + RB - 1) / RB;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int EXT_W = ROW_W + SH;
    localparam int PTR_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(ROWS + 1);
    localparam int CMP_W = (EXT_W + 1 > 9) ? EXT_W + 1 : 9;

    // control state
    logic [PTR_W-1:0] r_ptr;
    logic [ROWS-1:0]  r_row_valid;
    logic             r_out_valid;
    // working and payload registers
    logic [7:0]       r_slot;
    logic [ROW_W-1:0] r_scan_row;
    logic [CNT_W-1:0] r_chk;
    logic [1:0]       r_res_status;
    logic [6:0]       r_res_granted;
    logic             r_res_created;
    logic [1:0]       r_out_status;
    logic [6:0]       r_out_granted;
    logic             r_out_created;

    // input decode
    logic [1:0] in_action;
    logic       in_has;
    logic       in_slot_ok;
    nfsa_pkg::t_job in_job;

    assign in_action  = i_in_tuser[1:0];
    assign in_has     = i_in_tuser[2];
    assign in_slot_ok = CMP_W'(i_in_tdata) < CMP_W'(SLOT_COUNT);

    always_comb begin
        case (in_action)
            nfsa_pkg::ACT_ALLOC: in_job = in_has ? nfsa_pkg::JOB_IMM : nfsa_pkg::JOB_SCAN;
            nfsa_pkg::ACT_FREE:  in_job = (in_has && in_slot_ok) ? nfsa_pkg::JOB_FREE
                                                                  : nfsa_pkg::JOB_IMM;
            default:             in_job = nfsa_pkg::JOB_IMM;
        endcase
    end

    // address split of pointer and held slot
    logic [EXT_W-1:0] ptr_ext;
    logic [EXT_W-1:0] slot_ext;
    logic [ROW_W-1:0] start_row;
    logic [SH-1:0]    start_bit;
    logic [ROW_W-1:0] slot_row;
    logic [SH-1:0]    slot_bit;
    logic [ROW_W-1:0] next_row;

    assign ptr_ext   = EXT_W'(r_ptr);
    assign slot_ext  = EXT_W'(r_slot);
    assign start_row = ptr_ext[EXT_W-1:SH];
    assign start_bit = ptr_ext[SH-1:0];
    assign slot_row  = slot_ext[EXT_W-1:SH];
    assign slot_bit  = slot_ext[SH-1:0];
    assign next_row  = (r_scan_row == ROW_W'(ROWS - 1)) ? '0 : r_scan_row + 1'b1;

    // row under test; a never-written row reads as all free
    logic [RB-1:0] ram_q;
    logic [RB-1:0] row_eff;
    assign row_eff = r_row_valid[r_scan_row] ? ram_q : '0;

    logic first_chk;
    logic last_chk;
    assign first_chk = (r_chk == '0);
    assign last_chk  = (r_chk == CNT_W'(ROWS));

    // first check takes slots at or after the pointer, the final one
    // revisits the start row below the pointer
    logic [RB-1:0] mask;
    logic [RB-1:0] free_vec;
    logic          hit;
    logic [SH-1:0] hit_bit;

    always_comb begin
        for (int b = 0; b < RB; b++) begin
            logic in_pool;
            logic at_or_after;
            in_pool     = CMP_W'({r_scan_row, SH'(b)}) < CMP_W'(SLOT_COUNT);
            at_or_after = (SH'(b) >= start_bit);
            mask[b]     = in_pool && (first_chk ? at_or_after
                                                : (last_chk ? !at_or_after : 1'b1));
        end
    end

    assign free_vec = ~row_eff & mask;
    assign hit      = |free_vec;

    always_comb begin
        hit_bit = '0;
        for (int b = RB - 1; b >= 0; b--) begin
            if (free_vec[b]) begin
                hit_bit = SH'(b);
            end
        end
    end

    logic [EXT_W-1:0] hit_idx;
    logic [EXT_W:0]   idx_p1;
    logic [PTR_W-1:0] ptr_next;
    assign hit_idx  = {r_scan_row, hit_bit};
    assign idx_p1   = (EXT_W + 1)'(hit_idx) + 1'b1;
    assign ptr_next = (idx_p1 == (EXT_W + 1)'(SLOT_COUNT)) ? '0 : PTR_W'(idx_p1);

    // memory port control
    logic             scan_adv;
    logic             claim;
    logic             ram_re;
    logic [ROW_W-1:0] ram_raddr;
    logic             ram_we;
    logic [RB-1:0]    ram_wdata;

    assign scan_adv  = i_cmd.scan_step && !hit && !last_chk;
    assign claim     = i_cmd.scan_step && hit;
    assign ram_re    = i_cmd.free_rd || i_cmd.scan_rd || scan_adv;
    assign ram_raddr = i_cmd.free_rd ? slot_row : (i_cmd.scan_rd ? start_row : next_row);
    assign ram_we    = i_cmd.free_wr || claim;
    assign ram_wdata = i_cmd.free_wr ? (row_eff & ~(RB'(1) << slot_bit))
                                     : (row_eff | (RB'(1) << hit_bit));

    nfsa_ram #(
        .WIDTH (RB),
        .DEPTH (ROWS)
    ) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_scan_row),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load && in_action == nfsa_pkg::ACT_CLEAR) begin
                r_ptr <= '0;
            end else if (claim) begin
                r_ptr <= ptr_next;
            end
            if (ram_we) begin
                r_row_valid[r_scan_row] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_slot        <= i_in_tdata;
            r_res_created <= 1'b0;
            r_res_status  <= (in_has && !in_slot_ok &&
                              (in_action inside {nfsa_pkg::ACT_ALLOC, nfsa_pkg::ACT_FREE}))
                             ? nfsa_pkg::STAT_RANGE : nfsa_pkg::STAT_OK;
            r_res_granted <= (in_action == nfsa_pkg::ACT_ALLOC && in_has && in_slot_ok)
                             ? 7'(i_in_tdata) : '0;
        end
        if (i_cmd.free_rd) begin
            r_scan_row <= slot_row;
        end else if (i_cmd.scan_rd) begin
            r_scan_row <= start_row;
            r_chk      <= '0;
        end else if (scan_adv) begin
            r_scan_row <= next_row;
            r_chk      <= r_chk + 1'b1;
        end
        if (claim) begin
            r_res_granted <= 7'(hit_idx);
            r_res_created <= 1'b1;
        end else if (i_cmd.scan_step && last_chk) begin
            r_res_status <= nfsa_pkg::STAT_FULL;
        end
        if (i_cmd.out_load) begin
            r_out_status  <= r_res_status;
            r_out_granted <= r_res_granted;
            r_out_created <= r_res_created;
        end
    end

    assign o_sts.job      = in_job;
    assign o_sts.hit      = hit;
    assign o_sts.last_row = last_chk;
    assign o_sts.out_busy = r_out_valid && !i_out_tready;

    assign o_out_tvalid = r_out_valid;
    assign o_out_tdata  = {r_out_created, r_out_granted};
    assign o_out_tuser  = r_out_status;

endmodule

// ===== verif/tb_next_fit_slot_allocator.sv =====
// Self-checking testbench for next_fit_slot_allocator: directed and random
// allocate/free/clear traffic under varying stream backpressure.
// Depends on nfsa_pkg and the next_fit_slot_allocator RTL.
`timescale 1ns / 1ps

module tb_next_fit_slot_allocator;

    localparam int SLOT_COUNT  = 128;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RAND_ITEMS  = 652;
    localparam int BLOCK_LEN   = 50;    // items per fill or drain block
    localparam int MAX_REPORTS = 10;

    // Action 3 has no meaning; the block must answer it with an all-zero result.
    localparam logic [1:0] ACT_NOP = 2'd3;

    // One expected result transaction
    typedef struct {
        logic [1:0] status;
        logic [6:0] slot;
        logic       created;
    } t_grant;

    // Shadow copy of the pool plus the FIFO of grants still owed by the block.
    class slot_pool_scoreboard;
        bit       used_map [SLOT_COUNT];
        bit [6:0] next_ptr;
        t_grant   pending_grants [$];
        int       mismatches;

        function void note_request(logic [1:0] action, logic has_held, logic [7:0] held);
            t_grant exp_g;
            int     idx;
            exp_g = '{nfsa_pkg::STAT_OK, 7'd0, 1'b0};
            case (action)
                nfsa_pkg::ACT_ALLOC: begin
                    if (has_held) begin
                        // reuse: hand back the held slot, no state change
                        if (held < SLOT_COUNT) exp_g.slot = held[6:0];
                        else exp_g.status = nfsa_pkg::STAT_RANGE;
                    end else begin
                        // next-fit: first free slot from the pointer, wrapping
                        exp_g.status = nfsa_pkg::STAT_FULL;
                        for (int i = 0;
                             i < SLOT_COUNT && exp_g.status == nfsa_pkg::STAT_FULL;
                             i++) begin
                            idx = (next_ptr + i) % SLOT_COUNT;
                            if (!used_map[idx]) begin
                                used_map[idx] = 1'b1;
                                next_ptr      = 7'((idx + 1) % SLOT_COUNT);
                                exp_g.status  = nfsa_pkg::STAT_OK;
                                exp_g.slot    = idx[6:0];
                                exp_g.created = 1'b1;
                            end
                        end
                    end
                end
                nfsa_pkg::ACT_FREE: begin
                    if (has_held) begin
                        if (held < SLOT_COUNT) used_map[held[6:0]] = 1'b0;
                        else exp_g.status = nfsa_pkg::STAT_RANGE;
                    end
                end
                nfsa_pkg::ACT_CLEAR: next_ptr = '0;
                default: ;
            endcase
            pending_grants.push_back(exp_g);
        endfunction

        function void check_grant(logic [1:0] status, logic [6:0] slot, logic created);
            t_grant exp_g;
            if (pending_grants.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result status=%0d slot=%0d created=%0b",
                             $time, status, slot, created);
                return;
            end
            exp_g = pending_grants.pop_front();
            if (status !== exp_g.status || slot !== exp_g.slot ||
                created !== exp_g.created) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"%0t: result mismatch exp status=%0d slot=%0d created=%0b,",
                              " got status=%0d slot=%0d created=%0b"},
                             $time, exp_g.status, exp_g.slot, exp_g.created,
                             status, slot, created);
            end
        endfunction
    endclass

    // Clock, reset and the stream groups. Every input has a known value at time 0.
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = '0;     // [7:0] held_slot
    logic [2:0] s_axis_tuser  = '0;     // [1:0] action, [2] has_held_slot
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [6:0] granted_slot, [7] created
    logic [1:0] m_axis_tuser;           // [1:0] status

    // Idle knobs, percent per cycle; changed between traffic phases
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;

    slot_pool_scoreboard sb = new;

    next_fit_slot_allocator #(
        .SLOT_COUNT(SLOT_COUNT)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: random stalls, one fresh decision per cycle.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Values read right after the edge are the pre-edge ones, so a
    // transaction seen here is the one the block just handed over.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_grant(m_axis_tuser, m_axis_tdata[6:0], m_axis_tdata[7]);
    end

    // Offer one request and hold it until the block takes it. Idle cycles
    // ahead of it follow the current sender idle rate.
    task automatic send_request(input logic [1:0] action, input logic has_held,
                                input logic [7:0] held);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {has_held, action};
        s_axis_tdata  <= held;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(action, has_held, held);
    endtask

    // Random traffic in blocks: three fill blocks (mostly fresh allocations,
    // which runs the pool into full) then one drain block (mostly frees of
    // in-range slots). Clears, reuse, out-of-range indexes and the unused
    // action are mixed in throughout.
    task automatic run_random(input int count, input int first_idx);
        int         r;
        bit         fill;
        logic [1:0] act;
        logic       has_held;
        logic [7:0] held;
        for (int k = first_idx; k < first_idx + count; k++) begin
            fill     = ((k / BLOCK_LEN) % 4) != 3;
            r        = $urandom_range(0, 99);
            held     = 8'($urandom_range(0, 255));
            has_held = 1'($urandom_range(0, 1));
            if (fill) begin
                if (r < 80)      begin act = nfsa_pkg::ACT_ALLOC; has_held = 1'b0; end
                else if (r < 88) begin act = nfsa_pkg::ACT_ALLOC; has_held = 1'b1; end
                else if (r < 93) act = nfsa_pkg::ACT_FREE;
                else if (r < 97) act = nfsa_pkg::ACT_CLEAR;
                else             act = ACT_NOP;
            end else begin
                if (r < 50) begin
                    act      = nfsa_pkg::ACT_FREE;
                    has_held = 1'b1;
                    held     = 8'($urandom_range(0, SLOT_COUNT - 1));
                end
                else if (r < 60) act = nfsa_pkg::ACT_FREE;
                else if (r < 85) begin act = nfsa_pkg::ACT_ALLOC; has_held = 1'b0; end
                else if (r < 92) begin act = nfsa_pkg::ACT_ALLOC; has_held = 1'b1; end
                else if (r < 97) act = nfsa_pkg::ACT_CLEAR;
                else             act = ACT_NOP;
            end
            send_request(act, has_held, held);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: pointer behavior, clear, reuse, range errors, odd frees.
        send_request(nfsa_pkg::ACT_ALLOC, 1'b0, 8'h00);   // claims 0
        send_request(nfsa_pkg::ACT_ALLOC, 1'b0, 8'hFF);   // claims 1
        send_request(nfsa_pkg::ACT_CLEAR, 1'b0, 8'h00);   // pointer back to 0
        send_request(nfsa_pkg::ACT_ALLOC, 1'b0, 8'h55);   // skips used 0 and 1, claims 2
        send_request(nfsa_pkg::ACT_ALLOC, 1'b1, 8'd127);  // reuse of top slot
        send_request(nfsa_pkg::ACT_ALLOC, 1'b1, 8'd0);    // reuse of bottom slot
        send_request(nfsa_pkg::ACT_ALLOC, 1'b1, 8'd128);  // reuse just outside the pool
        send_request(nfsa_pkg::ACT_ALLOC, 1'b1, 8'd255);  // reuse far outside the pool
        send_request(nfsa_pkg::ACT_FREE,  1'b1, 8'd1);    // free a used slot
        send_request(nfsa_pkg::ACT_FREE,  1'b1, 8'd1);    // free it again, already free
        send_request(nfsa_pkg::ACT_FREE,  1'b0, 8'd2);    // nothing held: no effect
        send_request(nfsa_pkg::ACT_FREE,  1'b1, 8'd128);  // free outside the pool
        send_request(nfsa_pkg::ACT_FREE,  1'b1, 8'd255);
        send_request(nfsa_pkg::ACT_FREE,  1'b1, 8'd127);  // top slot, never claimed
        send_request(ACT_NOP,             1'b1, 8'hAA);   // unused action
        send_request(ACT_NOP,             1'b0, 8'h55);
        send_request(nfsa_pkg::ACT_ALLOC, 1'b0, 8'h00);   // claims 3
        send_request(nfsa_pkg::ACT_CLEAR, 1'b1, 8'hFF);   // clear ignores the other fields
        send_request(nfsa_pkg::ACT_ALLOC, 1'b0, 8'h00);   // refills freed slot 1
        send_request(nfsa_pkg::ACT_FREE,  1'b1, 8'd0);
        send_request(nfsa_pkg::ACT_ALLOC, 1'b0, 8'h00);   // claims 4, pointer past 1

        // Random traffic across four backpressure phases: none, sender idle,
        // receiver stalling, both sides lightly idle.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            run_random(RAND_ITEMS / 4, ph * (RAND_ITEMS / 4));
        end
        s_axis_tvalid <= 1'b0;

        // Drain: every owed result back, then a quiet margin longer than the
        // worst scan so a stray extra result would still be caught.
        while (sb.pending_grants.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending_grants.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
